@@ src/alst_pkg.sv @@
// Package for the LUT based sigmoid/tanh/ReLU activation unit.
// Holds widths, the pipeline record, the mode codes and the exp ROM builder.
// No dependencies.
package alst_pkg;

    localparam int LUT_ENTRIES = 256;
    localparam int IDX_W       = $clog2(LUT_ENTRIES);
    localparam int DATA_W      = 32;
    localparam int ENTRY_W     = 28;
    localparam int FRAC_W      = 20;
    localparam int OFF_W       = FRAC_W + 1;
    localparam int S_W         = OFF_W + IDX_W;
    localparam int PROD_W      = ENTRY_W + OFF_W;
    localparam int DEN_W       = ENTRY_W + 1;
    localparam int REM_W       = 33;
    localparam int QUO_W       = 17;
    localparam int TRIAL_W     = DEN_W + QUO_W - 1;

    localparam logic signed [33:0] ARG_LIMIT  = 34'sd524288;
    localparam logic [DATA_W-1:0]  Q16_ONE    = 32'd65536;
    localparam logic [REM_W-1:0]   DIVIDEND   = 33'h1_0000_0000;
    localparam logic [63:0]        ENTRY_MAX  = 64'h0FFF_FFFF;

    // Pipeline stage numbering.
    localparam int ST_ARG   = 0;
    localparam int ST_POS   = 1;
    localparam int ST_ROM   = 2;
    localparam int ST_MUL   = 3;
    localparam int ST_INT   = 4;
    localparam int ST_DIV0  = 5;
    localparam int ST_DIVN  = ST_DIV0 + QUO_W - 1;
    localparam int ST_OUT   = ST_DIVN + 1;
    localparam int NUM_ST   = ST_OUT + 1;

    typedef enum logic [1:0] {
        MODE_RELU     = 2'd0,
        MODE_SIGMOID  = 2'd1,
        MODE_TANH     = 2'd2,
        MODE_IDENTITY = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic                      last;
        logic signed [DATA_W-1:0]  x;
        logic [OFF_W-1:0]          off;
        logic [IDX_W-1:0]          idx;
        logic [OFF_W-1:0]          frac;
        logic [ENTRY_W-1:0]        lo;
        logic [ENTRY_W-1:0]        hi;
        logic                      down;
        logic [PROD_W-1:0]         prod;
        logic [DEN_W-1:0]          den;
        logic [REM_W-1:0]          rem;
        logic [QUO_W-1:0]          quo;
        logic [DATA_W-1:0]         res;
    } pipe_t;

    typedef logic [ENTRY_W-1:0] exp_rom_t [LUT_ENTRIES];

    // Unsigned 64-bit quotient n / d by restoring steps; used only for the ROM contents.
    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // (a * b) >> 47, low 64 bits kept.
    function automatic logic [63:0] mul_q47(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[110:47];
    endfunction

    // exp(a) in Q47 for 0 <= a <= 8, Taylor series up to the a^64 term.
    function automatic logic [63:0] exp_q47(input logic [63:0] a);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = 64'd1 << 47;
        term = 64'd1 << 47;
        for (int k = 1; k <= 64; k++)
        begin
            term = div_u64(mul_q47(term, a), 64'(k));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Builds the exponential table on the grid -8 + 16*i/(LUT_ENTRIES-1).
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] eight;
        logic [63:0] pos;
        logic [63:0] e;
        logic [63:0] v;
        eight = 64'd1 << 50;
        for (int i = 0; i < LUT_ENTRIES; i++)
        begin
            pos = div_u64(64'(i) << 51, 64'(LUT_ENTRIES - 1));
            if (pos >= eight)
            begin
                e = exp_q47(pos - eight);
                v = (e + (64'd1 << 30)) >> 31;
            end
            else
            begin
                e = exp_q47(eight - pos);
                v = div_u64((64'd1 << 63) + (e >> 1), e);
            end
            if (v > ENTRY_MAX)
            begin
                v = ENTRY_MAX;
            end
            rom[i] = v[ENTRY_W-1:0];
        end
        return rom;
    endfunction

endpackage

@@ src/activation_lut_sigmoid_tanh_top.sv @@
// Top level of the streaming activation unit (ReLU, sigmoid, tanh, identity).
// Depends on alst_pkg for widths, the pipeline record and the exp ROM contents.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data[1:0] (mode)
//  in      | in        | in_valid / in_ready   | sample[31:0] signed, last_in
//  out     | out       | out_valid / out_ready | activated[31:0] signed, last_out
//
// One sample enters per cycle unless output back pressure has filled the pipeline;
// its depth is set mostly by the 17 restoring steps of the pipelined reciprocal divider.
// Reset (rst_n low) clears every stage valid bit and sets the mode to ReLU;
// the exp ROM is a constant table and needs no fill.
// Each stage holds its item while the stage after it is full and not moving,
// so back pressure squeezes out bubbles first and no transfer is lost or repeated.
module activation_lut_sigmoid_tanh_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    input  logic               last_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] activated,
    output logic               last_out
);

    localparam alst_pkg::exp_rom_t EXP_ROM = alst_pkg::build_exp_rom();

    alst_pkg::mode_t mode_reg;
    alst_pkg::pipe_t p_reg  [alst_pkg::NUM_ST];
    alst_pkg::pipe_t p_next [alst_pkg::NUM_ST];
    logic [alst_pkg::NUM_ST-1:0] v_reg;
    logic [alst_pkg::NUM_ST-1:0] en;

    // Each item carries the mode it entered with, so a write applies from the next transfer on.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= alst_pkg::MODE_RELU;
        end
        else if (cfg_valid)
        begin
            mode_reg <= alst_pkg::mode_t'(cfg_data);
        end
    end

    // A stage may load when it is empty or when its content moves on.
    always_comb
    begin
        en[alst_pkg::NUM_ST-1] = !v_reg[alst_pkg::NUM_ST-1] || out_ready;
        for (int i = alst_pkg::NUM_ST - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    // Datapath of every stage.
    always_comb
    begin
        logic signed [33:0]         arg;
        logic [alst_pkg::S_W-1:0]     s;
        logic [alst_pkg::S_W-1:0]     fr;
        logic [alst_pkg::IDX_W:0]     idx_raw;
        logic [alst_pkg::ENTRY_W-1:0] diff;
        logic [alst_pkg::PROD_W-1:0]  adj;
        logic [alst_pkg::ENTRY_W-1:0] step;
        logic [alst_pkg::ENTRY_W-1:0] e;
        logic [alst_pkg::TRIAL_W-1:0] trial;
        alst_pkg::pipe_t            q;

        // Exponential argument: -x for sigmoid, -2x for tanh, clamped to [-8, 8].
        q      = p_reg[alst_pkg::ST_ARG];
        q.mode = mode_reg;
        q.last = last_in;
        q.x    = sample;
        if (mode_reg == alst_pkg::MODE_TANH)
        begin
            arg = -(34'(sample) <<< 1);
        end
        else
        begin
            arg = -34'(sample);
        end
        if (arg < -alst_pkg::ARG_LIMIT)
        begin
            arg = -alst_pkg::ARG_LIMIT;
        end
        else if (arg > alst_pkg::ARG_LIMIT)
        begin
            arg = alst_pkg::ARG_LIMIT;
        end
        q.off = alst_pkg::OFF_W'(arg + alst_pkg::ARG_LIMIT);
        p_next[alst_pkg::ST_ARG] = q;

        // Table position, index and Q20 fraction.
        q       = p_reg[alst_pkg::ST_ARG];
        s       = alst_pkg::S_W'(q.off) * alst_pkg::S_W'(alst_pkg::LUT_ENTRIES - 1);
        idx_raw = s[alst_pkg::S_W-1:alst_pkg::FRAC_W];
        if (idx_raw > (alst_pkg::IDX_W+1)'(alst_pkg::LUT_ENTRIES - 2))
        begin
            idx_raw = (alst_pkg::IDX_W+1)'(alst_pkg::LUT_ENTRIES - 2);
        end
        q.idx  = idx_raw[alst_pkg::IDX_W-1:0];
        fr     = s - (alst_pkg::S_W'(idx_raw) << alst_pkg::FRAC_W);
        q.frac = fr[alst_pkg::OFF_W-1:0];
        p_next[alst_pkg::ST_POS] = q;

        // Neighboring table entries.
        q    = p_reg[alst_pkg::ST_POS];
        q.lo = EXP_ROM[q.idx];
        q.hi = EXP_ROM[q.idx + alst_pkg::IDX_W'(1)];
        p_next[alst_pkg::ST_ROM] = q;

        // Difference times fraction.
        q      = p_reg[alst_pkg::ST_ROM];
        q.down = q.hi < q.lo;
        diff   = q.down ? (q.lo - q.hi) : (q.hi - q.lo);
        q.prod = alst_pkg::PROD_W'(diff) * alst_pkg::PROD_W'(q.frac);
        p_next[alst_pkg::ST_MUL] = q;

        // Interpolated exponential; a falling segment rounds its step up.
        q = p_reg[alst_pkg::ST_MUL];
        if (q.down)
        begin
            adj  = q.prod + alst_pkg::PROD_W'((1 << alst_pkg::FRAC_W) - 1);
            step = adj[alst_pkg::FRAC_W +: alst_pkg::ENTRY_W];
            e    = q.lo - step;
        end
        else
        begin
            adj  = q.prod;
            step = adj[alst_pkg::FRAC_W +: alst_pkg::ENTRY_W];
            e    = q.lo + step;
        end
        q.den = alst_pkg::DEN_W'(e) + alst_pkg::DEN_W'(alst_pkg::Q16_ONE);
        q.rem = alst_pkg::DIVIDEND;
        q.quo = '0;
        p_next[alst_pkg::ST_INT] = q;

        // Restoring division of 2^32 by the denominator, one quotient bit per stage.
        for (int j = 0; j < alst_pkg::QUO_W; j++)
        begin
            q     = p_reg[alst_pkg::ST_INT + j];
            trial = alst_pkg::TRIAL_W'(q.den) << (alst_pkg::QUO_W - 1 - j);
            if (alst_pkg::TRIAL_W'(q.rem) >= trial)
            begin
                q.rem = q.rem - alst_pkg::REM_W'(trial);
                q.quo[alst_pkg::QUO_W-1-j] = 1'b1;
            end
            p_next[alst_pkg::ST_DIV0 + j] = q;
        end

        // Output selection.
        q = p_reg[alst_pkg::ST_DIVN];
        unique case (q.mode)
            alst_pkg::MODE_RELU:
            begin
                q.res = (!q.x[alst_pkg::DATA_W-1] && q.x != '0) ? q.x : '0;
            end
            alst_pkg::MODE_SIGMOID:
            begin
                q.res = alst_pkg::DATA_W'(q.quo);
            end
            alst_pkg::MODE_TANH:
            begin
                q.res = (alst_pkg::DATA_W'(q.quo) << 1) - alst_pkg::Q16_ONE;
            end
            default:
            begin
                q.res = q.x;
            end
        endcase
        p_next[alst_pkg::ST_OUT] = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < alst_pkg::NUM_ST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[(i == 0) ? 0 : i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < alst_pkg::NUM_ST; i++)
        begin
            if (en[i])
            begin
                p_reg[i] <= p_next[i];
            end
        end
    end

    assign out_valid = v_reg[alst_pkg::ST_OUT];
    assign activated = p_reg[alst_pkg::ST_OUT].res;
    assign last_out  = p_reg[alst_pkg::ST_OUT].last;

    // The input side only stalls when the whole pipeline is full behind a held result.
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready && (&v_reg)))
        else $error("input stalled without output back pressure");

    // After the last division step the remainder is below the denominator.
    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[alst_pkg::ST_DIVN] |->
            (p_reg[alst_pkg::ST_DIVN].rem < alst_pkg::REM_W'(p_reg[alst_pkg::ST_DIVN].den)))
        else $error("reciprocal remainder not reduced");

    // Sigmoid results lie in [0, 1] in Q16.
    a_sigmoid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && p_reg[alst_pkg::ST_OUT].mode == alst_pkg::MODE_SIGMOID) |->
            (activated >= 0 && activated <= 32'sd65536))
        else $error("sigmoid result out of range");

endmodule

@@ dv/tb.sv @@
// Testbench for activation_lut_sigmoid_tanh_top: random and directed samples in all modes.
// Uses alst_pkg for the mode codes; predicts results with its own exp table and datapath.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_N   = 256;
    localparam int DRAIN_CYC = 40;
    localparam int STALL_MAX = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] sample;
    logic               last_in;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] activated;
    logic               last_out;

    activation_lut_sigmoid_tanh_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .activated (activated),
        .last_out  (last_out)
    );

    typedef struct {
        logic [31:0] value;
        logic        last;
    } act_result_t;

    logic [27:0]      exp_rom [TABLE_N];
    alst_pkg::mode_t  cur_mode;
    act_result_t      pending_results[$];
    int               gap_pct;
    int               stall_pct;
    int               errors;
    int               samples_sent;
    int               results_seen;
    int               quiet_cycles;

    // The clock runs with a 12 ns period; all stimulus changes on the falling edge.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Exponential of a nonnegative Q47 argument by a Taylor series up to the a^64 term.
    function automatic logic [63:0] taylor_exp(input logic [63:0] a);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        sum  = 64'd1 << 47;
        term = 64'd1 << 47;
        for (int k = 1; k <= 64; k++)
        begin
            prod = {64'd0, term} * {64'd0, a};
            term = prod[110:47] / 64'(k);
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Fills the table with exp() on the grid -8 + 16*i/(N-1), entries in Q12.16.
    task automatic fill_exp_rom();
        logic [63:0] grid_pos;
        logic [63:0] e;
        logic [63:0] v;
        for (int i = 0; i < TABLE_N; i++)
        begin
            grid_pos = (64'(i) << 51) / 64'(TABLE_N - 1);
            if (grid_pos >= (64'd1 << 50))
            begin
                e = taylor_exp(grid_pos - (64'd1 << 50));
                v = (e + (64'd1 << 30)) >> 31;
            end
            else
            begin
                e = taylor_exp((64'd1 << 50) - grid_pos);
                v = ((64'd1 << 63) + (e >> 1)) / e;
            end
            if (v > 64'h0FFF_FFFF)
                v = 64'h0FFF_FFFF;
            exp_rom[i] = v[27:0];
        end
    endtask

    // Interpolated exp of a Q16 argument, clamped to [-8, 8]; result in Q16.
    function automatic logic [63:0] interp_exp(input longint arg);
        longint      a;
        logic [63:0] pos;
        logic [63:0] idx;
        logic [63:0] frac;
        logic [63:0] lo;
        logic [63:0] hi;
        a = arg;
        if (a < -524288)
            a = -524288;
        if (a > 524288)
            a = 524288;
        pos = 64'(a + 524288) * 64'(TABLE_N - 1);
        idx = pos >> 20;
        if (idx > 64'(TABLE_N - 2))
            idx = 64'(TABLE_N - 2);
        frac = pos - (idx << 20);
        lo   = 64'(exp_rom[idx]);
        hi   = 64'(exp_rom[idx + 1]);
        if (hi >= lo)
            return lo + (((hi - lo) * frac) >> 20);
        return lo - ((((lo - hi) * frac) + 64'hF_FFFF) >> 20);
    endfunction

    function automatic longint logistic(input longint arg);
        return longint'((64'd1 << 32) / (64'd65536 + interp_exp(arg)));
    endfunction

    function automatic logic [31:0] predict_activation(input alst_pkg::mode_t m,
                                                        input logic signed [31:0] x);
        longint xv;
        longint r;
        xv = longint'(x);
        case (m)
            alst_pkg::MODE_RELU:    r = (xv > 0) ? xv : 0;
            alst_pkg::MODE_SIGMOID: r = logistic(-xv);
            alst_pkg::MODE_TANH:    r = 2 * logistic(-2 * xv) - 65536;
            default:                r = xv;
        endcase
        return r[31:0];
    endfunction

    // Mostly samples near the interesting range of sigmoid and tanh, some anywhere.
    function automatic logic [31:0] random_sample();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return 32'($signed($urandom_range(1310720)) - 655360);
        if (pick < 8)
            return 32'($signed($urandom_range(65536)) - 32768);
        return $urandom;
    endfunction

    // Sends one sample; the expected result is queued at the transfer edge.
    task automatic send_sample(input logic [31:0] x, input logic last);
        act_result_t exp_res;
        while ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= x;
        last_in  <= last;
        do
            @(posedge clk);
        while (!in_ready);
        exp_res.value = predict_activation(cur_mode, x);
        exp_res.last  = last;
        pending_results.push_back(exp_res);
        samples_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    // Mode writes happen only with the pipeline empty.
    task automatic write_mode(input alst_pkg::mode_t m);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_mode = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        logic [31:0]     edges [6];
        alst_pkg::mode_t m;
        edges = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0008_0000, 32'hFFF7_FFFF, 32'hFFFF_FFFF};
        gap_pct   = 0;
        stall_pct = 0;
        for (int i = 0; i < 4; i++)
        begin
            m = alst_pkg::mode_t'(2'(i));
            write_mode(m);
            foreach (edges[j])
                send_sample(edges[j], 1'(j & 1));
        end
        // Tanh doubles the argument, so +-4.0 and just past it hit the table ends.
        write_mode(alst_pkg::MODE_TANH);
        send_sample(32'h0004_0000, 1'b0);
        send_sample(32'hFFFC_0000, 1'b1);
        send_sample(32'h0004_0001, 1'b0);
    endtask

    task automatic test_random_mode(input alst_pkg::mode_t m, input int count);
        write_mode(m);
        for (int i = 0; i < count; i++)
            send_sample(random_sample(), 1'($urandom_range(7) == 0));
    endtask

    // Sender holds off until the pipeline is empty in the middle of a stream.
    task automatic test_pause_drain();
        write_mode(alst_pkg::MODE_SIGMOID);
        for (int i = 0; i < 20; i++)
            send_sample(random_sample(), 1'b0);
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_sample(random_sample(), 1'($urandom_range(1)));
    endtask

    always @(negedge clk)
        if (rst_n)
            out_ready <= ($urandom_range(99) >= stall_pct);

    // Each output transfer is checked against the oldest queued expectation.
    always @(posedge clk)
    begin
        act_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result activated=%h last=%b",
                         $time, activated, last_out);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (activated !== want.value)
                begin
                    $display("%0t: activated expected %h actual %h",
                             $time, want.value, activated);
                    errors++;
                end
                if (last_out !== want.last)
                begin
                    $display("%0t: last_out expected %b actual %b",
                             $time, want.last, last_out);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any transfer ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int gaps [4];
        int stalls [4];
        gaps   = '{0, 58, 0, 33};
        stalls = '{0, 0, 58, 33};
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 2'd0;
        in_valid     = 1'b0;
        sample       = '0;
        last_in      = 1'b0;
        out_ready    = 1'b0;
        errors       = 0;
        samples_sent = 0;
        results_seen = 0;
        quiet_cycles = 0;
        cur_mode     = alst_pkg::MODE_RELU;
        gap_pct      = 0;
        stall_pct    = 0;
        fill_exp_rom();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        for (int p = 0; p < 4; p++)
        begin
            gap_pct   = gaps[p];
            stall_pct = stalls[p];
            test_random_mode(alst_pkg::MODE_RELU, 50);
            test_random_mode(alst_pkg::MODE_SIGMOID, 100);
            test_random_mode(alst_pkg::MODE_TANH, 100);
            test_random_mode(alst_pkg::MODE_IDENTITY, 50);
        end
        gap_pct   = 33;
        stall_pct = 33;
        test_pause_drain();
        test_random_mode(alst_pkg::MODE_TANH, 60);
        test_random_mode(alst_pkg::MODE_RELU, 20);
        wait_drained();

        $display("Covered %0d samples and %0d results over all four modes,",
                 samples_sent, results_seen);
        $display("with source gaps, sink stalls and a mid-stream drain.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
